FILE: rtl/core/tsd_pkg.sv
// ----------------------------------------------------------------------------
// tsd_pkg - shared types and constants of the scratchpad decoder
// Command and status bundles, byte positions, result codes, CRC-8 and the
// resolution lookup.
// ----------------------------------------------------------------------------
package tsd_pkg;

   localparam int SCRATCH_BYTES = 9;
   localparam int IDX_W         = 4;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SCRATCH_BYTES - 1);

   // scratchpad byte positions
   localparam logic [IDX_W-1:0] IDX_TEMP_LO = 4'd0;
   localparam logic [IDX_W-1:0] IDX_TEMP_HI = 4'd1;
   localparam logic [IDX_W-1:0] IDX_CONFIG  = 4'd4;
   localparam logic [IDX_W-1:0] IDX_REMAIN  = 4'd6;
   localparam logic [IDX_W-1:0] IDX_PER_DEG = 4'd7;

   localparam logic [7:0]  FAMILY_EXT     = 8'h10;
   localparam logic [7:0]  CRC_POLY       = 8'h8C;
   localparam logic [15:0] OFFSET_QUARTER = 16'd32;

   // result status codes
   localparam logic [1:0] STS_OK       = 2'd0;
   localparam logic [1:0] STS_CRC_BAD  = 2'd1;
   localparam logic [1:0] STS_ZERO_CPD = 2'd2;

   // configuration byte codes
   localparam logic [7:0] CFG_RES12 = 8'h7F;
   localparam logic [7:0] CFG_RES11 = 8'h5F;
   localparam logic [7:0] CFG_RES10 = 8'h3F;
   localparam logic [7:0] CFG_RES9  = 8'h1F;
   localparam logic [3:0] RES_EXT   = 4'd12;

   // divider: 16 quotient bits, one per cycle
   localparam int DIV_STEPS = 16;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   typedef struct packed {
      logic accept;    // input word taken this cycle
      logic div_step;  // one restoring-division step
      logic div_done;  // fold quotient into the temperature
   } cmd_type;

   typedef struct packed {
      logic last;      // incoming word is the CRC byte
      logic need_div;  // CRC byte of a good-CRC extended form with nonzero count per degree
   } sts_type;

   function automatic logic [7:0] crc_update(input logic [7:0] crc,
                                             input logic [7:0] data);
      logic [7:0] c;
      logic [7:0] d;
      logic       mix;
      c = crc;
      d = data;
      for (int k = 0; k < 8; k++) begin
         mix = c[0] ^ d[0];
         c   = c >> 1;
         if (mix) begin
            c = c ^ CRC_POLY;
         end
         d = d >> 1;
      end
      return c;
   endfunction

   function automatic logic [3:0] decode_resolution(input logic [7:0] cfg);
      logic [3:0] res;
      unique case (cfg)
         CFG_RES12: res = 4'd12;
         CFG_RES11: res = 4'd11;
         CFG_RES10: res = 4'd10;
         CFG_RES9:  res = 4'd9;
         default:   res = 4'd0;
      endcase
      return res;
   endfunction

endpackage

FILE: rtl/core/tsd_ctrl.sv
// ----------------------------------------------------------------------------
// tsd_ctrl - sequencer of the scratchpad decoder
// Takes bytes, runs the 16-step divider when needed and holds the result
// word until the sink takes it.
// ----------------------------------------------------------------------------
module tsd_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  tsd_pkg::sts_type sts,
   output tsd_pkg::cmd_type cmd
);
   import tsd_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] step_cnt_ff, step_cnt_in;
   logic             take;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign take       = req_tvalid && req_tready;

   always_comb begin
      state_in     = state_ff;
      step_cnt_in  = step_cnt_ff;
      cmd.accept   = take;
      cmd.div_step = 1'b0;
      cmd.div_done = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (take && sts.last) begin
               step_cnt_in = '0;
               state_in    = sts.need_div ? ST_DIV : ST_OUT;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_cnt_in  = step_cnt_ff + 1'b1;
            if (step_cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            cmd.div_done = 1'b1;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         step_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         step_cnt_ff <= step_cnt_in;
      end
   end

   // a CRC byte always leads to a result, through the divider or not
   a_last_to_result: assert property (@(posedge clock) disable iff (reset)
      (take && sts.last) |=> (state_ff == ST_DIV || state_ff == ST_OUT))
      else $error("CRC byte did not start a result");

   // divider runs exactly its full step count
   a_div_len: assert property (@(posedge clock) disable iff (reset)
      cmd.div_done |-> $past(step_cnt_ff) == CNT_W'(DIV_STEPS - 1))
      else $error("divider finished early");

   // no byte taken while a result is being built or held
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_step || rsp_tvalid) |-> !cmd.accept)
      else $error("byte accepted while busy");

endmodule

FILE: rtl/core/tsd_datapath.sv
// ----------------------------------------------------------------------------
// tsd_datapath - byte store, CRC-8 and temperature arithmetic
// Keeps the scratchpad fields, the running CRC, a restoring divider and the
// result register.
// ----------------------------------------------------------------------------
module tsd_datapath (
   input  logic              clock,
   input  logic              reset,
   input  logic [7:0]        data_byte,
   input  logic              first_byte,
   input  logic [7:0]        family_code,
   input  tsd_pkg::cmd_type  cmd,
   output tsd_pkg::sts_type  sts,
   output logic signed [15:0] temperature_raw,
   output logic [1:0]        status,
   output logic [3:0]        resolution_bits
);
   import tsd_pkg::*;

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]       crc_ff, crc_in;

   logic [7:0] lo_ff, hi_ff, cfg_ff, remain_ff, cpd_ff;

   // divider
   logic [15:0] quo_ff;
   logic [8:0]  rem_ff;
   logic [7:0]  den_ff;
   logic        neg_ff;
   logic [15:0] base_ff;

   logic [15:0] res_temp_ff;
   logic [1:0]  res_status_ff;
   logic [3:0]  res_resol_ff;

   logic [IDX_W-1:0] idx_eff;
   logic [7:0]       crc_eff;
   logic             last, crc_ok, ext, cpd_zero;
   logic [15:0]      raw, base;
   logic [8:0]       diff, mag;
   logic [8:0]       trial;
   logic             ge;
   logic [15:0]      quo_signed;

   assign idx_eff  = first_byte ? '0 : idx_ff;
   assign crc_eff  = first_byte ? 8'd0 : crc_ff;
   assign last     = (idx_eff == IDX_LAST);
   assign crc_ok   = (crc_eff == data_byte);
   assign ext      = (family_code == FAMILY_EXT);
   assign cpd_zero = (cpd_ff == 8'd0);

   assign sts.last     = last;
   assign sts.need_div = last && crc_ok && ext && !cpd_zero;

   // raw value in 1/128 degree; extended base drops the half-degree bit
   assign raw  = {hi_ff[4:0], lo_ff, 3'b000};
   assign base = {raw[12:4], 7'd0} - OFFSET_QUARTER;
   assign diff = {1'b0, cpd_ff} - {1'b0, remain_ff};
   assign mag  = diff[8] ? (9'd0 - diff) : diff;

   assign trial      = {rem_ff[7:0], quo_ff[15]};
   assign ge         = (trial >= {1'b0, den_ff});
   assign quo_signed = neg_ff ? (16'd0 - quo_ff) : quo_ff;

   always_comb begin
      idx_in = idx_ff;
      crc_in = crc_ff;
      if (cmd.accept) begin
         if (last) begin
            idx_in = '0;
            crc_in = 8'd0;
         end else begin
            idx_in = idx_eff + 1'b1;
            crc_in = crc_update(crc_eff, data_byte);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         crc_ff <= 8'd0;
      end else begin
         idx_ff <= idx_in;
         crc_ff <= crc_in;
      end
   end

   // field store, result setup and divider steps
   always_ff @(posedge clock) begin
      if (cmd.accept && !last) begin
         unique case (idx_eff)
            IDX_TEMP_LO: lo_ff     <= data_byte;
            IDX_TEMP_HI: hi_ff     <= data_byte;
            IDX_CONFIG:  cfg_ff    <= data_byte;
            IDX_REMAIN:  remain_ff <= data_byte;
            IDX_PER_DEG: cpd_ff    <= data_byte;
            default: ;
         endcase
      end
      if (cmd.accept && last) begin
         if (!crc_ok) begin
            res_status_ff <= STS_CRC_BAD;
            res_temp_ff   <= 16'd0;
         end else if (!ext) begin
            res_status_ff <= STS_OK;
            res_temp_ff   <= raw;
         end else if (cpd_zero) begin
            res_status_ff <= STS_ZERO_CPD;
            res_temp_ff   <= 16'd0;
         end else begin
            res_status_ff <= STS_OK;
            res_temp_ff   <= 16'd0;
         end
         res_resol_ff <= ext ? RES_EXT : (crc_ok ? decode_resolution(cfg_ff) : 4'd0);
         quo_ff  <= {1'b0, mag[7:0], 7'd0};
         rem_ff  <= 9'd0;
         den_ff  <= cpd_ff;
         neg_ff  <= diff[8];
         base_ff <= base;
      end
      if (cmd.div_step) begin
         rem_ff <= ge ? (trial - {1'b0, den_ff}) : trial;
         quo_ff <= {quo_ff[14:0], ge};
      end
      if (cmd.div_done) begin
         res_temp_ff <= base_ff + quo_signed;
      end
   end

   assign temperature_raw = res_temp_ff;
   assign status          = res_status_ff;
   assign resolution_bits = res_resol_ff;

   // partial remainder stays below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (rem_ff < {1'b0, den_ff}))
      else $error("divider remainder out of range");

endmodule

FILE: rtl/core/temp_scratchpad_decoder.sv
// ----------------------------------------------------------------------------
// temp_scratchpad_decoder - 1-Wire temperature scratchpad decoder
// Checks the CRC-8 over a nine-byte scratchpad and returns the temperature in
// 1/128 degree with status and resolution.
// ----------------------------------------------------------------------------
//
//   channel | dir | word contents (lsb first)
//   --------+-----+------------------------------------------------------
//   req_    | in  | tdata: data_byte[7:0], family_code[15:8]; tuser: first_byte
//   rsp_    | out | tdata: temperature_raw[15:0], resolution_bits[19:16],
//           |     |        zero pad[23:20]; tuser: status
//
// Bytes 0..7 are taken one per cycle; nothing comes out for them.
// The CRC byte yields one result word: in the next cycle when no division is
// needed; for the extended form with good CRC and nonzero count per degree,
// after the 16 steps of the bit-serial divider and one step adding the quotient.
// req_tready is low from the CRC byte until the result word is taken, so a
// stalled sink stalls the source.
// Synchronous active-high reset clears the byte count, CRC and sequencer.
//
module temp_scratchpad_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // data_byte[7:0], family_code[15:8]
   input  logic        req_tuser,   // first_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // temperature_raw[15:0], resolution_bits[19:16]
   output logic [1:0]  rsp_tuser    // status[1:0]
);
   import tsd_pkg::*;

   cmd_type            cmd;
   sts_type            sts;
   logic signed [15:0] temperature_raw;
   logic [1:0]         status;
   logic [3:0]         resolution_bits;

   // sequencer: handshakes and divider timing
   tsd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // datapath: byte store, CRC, divider, result register
   tsd_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .data_byte       (req_tdata[7:0]),
      .first_byte      (req_tuser),
      .family_code     (req_tdata[15:8]),
      .cmd             (cmd),
      .sts             (sts),
      .temperature_raw (temperature_raw),
      .status          (status),
      .resolution_bits (resolution_bits)
   );

   assign rsp_tdata = {4'd0, resolution_bits, temperature_raw};
   assign rsp_tuser = status;

endmodule
